// File: src/escaped_api_tx_frame_builder_unit_macros.svh
// Assertion macros for the escaped API transmit frame builder.
// Used by the port checker; relies on signals named clock and reset in scope.
`ifndef ESCAPED_API_TX_FRAME_BUILDER_UNIT_MACROS_SVH
`define ESCAPED_API_TX_FRAME_BUILDER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EATFB_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("eatfb check failed");

// Consequent must hold in the cycle after the antecedent.
`define EATFB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("eatfb check failed");

`endif

// File: src/eatfb_pkg.sv
// Shared types and constants for the escaped API transmit frame builder.
// No dependencies; the other source files, apart from the macro header, refer to it by scoped names.
package eatfb_pkg;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] dest_address;
      logic [15:0] payload_length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       run_last;
   } rsp_type;

   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_PAYLOAD = 2'd1;
   localparam logic [1:0] CMD_FINISH  = 2'd2;

   localparam logic [1:0] CSR_FRAME_IDENT      = 2'd0;
   localparam logic [1:0] CSR_BROADCAST_RADIUS = 2'd1;
   localparam logic [1:0] CSR_TX_OPTIONS       = 2'd2;

   typedef enum logic [1:0] {
      JOB_START  = 2'd0,
      JOB_DATA   = 2'd1,
      JOB_FINISH = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [63:0]  dest_address;
      logic [15:0]  frame_length;
      logic [7:0]   data_byte;
   } job_type;

   typedef struct packed {
      logic [7:0] frame_ident;
      logic [7:0] broadcast_radius;
      logic [7:0] tx_options;
   } cfg_type;

   localparam logic [7:0]  START_DELIM       = 8'h7E;
   localparam logic [7:0]  ESC_BYTE          = 8'h7D;
   localparam logic [7:0]  XON_BYTE          = 8'h11;
   localparam logic [7:0]  XOFF_BYTE         = 8'h13;
   localparam logic [7:0]  ESC_MASK          = 8'h20;
   localparam logic [7:0]  FRAME_TYPE_TX     = 8'h10;
   localparam logic [7:0]  RSVD_HI           = 8'hFF;
   localparam logic [7:0]  RSVD_LO           = 8'hFE;
   localparam logic [7:0]  CHECKSUM_BASE     = 8'hFF;
   localparam logic [7:0]  FRAME_IDENT_RESET = 8'h01;
   localparam logic [15:0] LENGTH_OVERHEAD   = 16'd14;

   // Raw header byte positions (start delimiter is position zero).
   localparam logic [4:0] HDR_LEN_HI     = 5'd1;
   localparam logic [4:0] HDR_LEN_LO     = 5'd2;
   localparam logic [4:0] HDR_TYPE       = 5'd3;
   localparam logic [4:0] HDR_IDENT      = 5'd4;
   localparam logic [4:0] HDR_ADDR_FIRST = 5'd5;
   localparam logic [4:0] HDR_ADDR_LAST  = 5'd12;
   localparam logic [4:0] HDR_RSVD_HI    = 5'd13;
   localparam logic [4:0] HDR_RSVD_LO    = 5'd14;
   localparam logic [4:0] HDR_RADIUS     = 5'd15;
   localparam logic [4:0] HDR_OPTIONS    = 5'd16;

   // Wire beats a start item may produce; the rest spill to the next item.
   localparam logic [4:0] START_WIRE_CAP = 5'd27;

   function automatic logic needs_escape(input logic [7:0] b);
      needs_escape = (b == START_DELIM) || (b == ESC_BYTE) ||
                     (b == XON_BYTE) || (b == XOFF_BYTE);
   endfunction

endpackage

// File: src/eatfb_front.sv
// Front end: accepts request beats, tracks whether a frame is open, turns
// starts and in-frame beats into queue jobs and drops the rest. Depends on eatfb_pkg.
module eatfb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  eatfb_pkg::req_type  req,
   output logic                push_valid,
   input  logic                push_ready,
   output eatfb_pkg::job_type  push_job
);

   logic frame_open_ff;
   logic frame_open_in;
   logic push_wanted;
   logic accept;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;
   assign push_valid = req_valid && push_wanted;

   always_comb begin
      push_job.dest_address = req.dest_address;
      push_job.frame_length = req.payload_length + eatfb_pkg::LENGTH_OVERHEAD;
      push_job.data_byte    = req.data_byte;
      push_job.kind         = eatfb_pkg::JOB_DATA;
      push_wanted           = 1'b0;
      frame_open_in         = frame_open_ff;
      case (req.command)
         eatfb_pkg::CMD_START: begin
            push_job.kind = eatfb_pkg::JOB_START;
            push_wanted   = 1'b1;
            if (accept) begin
               frame_open_in = 1'b1;
            end
         end
         eatfb_pkg::CMD_PAYLOAD: begin
            push_job.kind = eatfb_pkg::JOB_DATA;
            push_wanted   = frame_open_ff;
         end
         eatfb_pkg::CMD_FINISH: begin
            push_job.kind = eatfb_pkg::JOB_FINISH;
            push_wanted   = frame_open_ff;
            if (accept) begin
               frame_open_in = 1'b0;
            end
         end
         default: begin
            // drop: no job, no change
            push_wanted = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
      end else begin
         frame_open_ff <= frame_open_in;
      end
   end

endmodule

// File: src/eatfb_queue.sv
// Short job queue between the front end and the byte sequencer.
// Register storage with wrapping pointers. Depends on eatfb_pkg.
module eatfb_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  eatfb_pkg::job_type in_job,
   output logic               out_valid,
   input  logic               out_ready,
   output eatfb_pkg::job_type out_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   eatfb_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

// File: src/eatfb_back.sv
// Back end: expands jobs into escaped wire beats, one per cycle unless rsp stalls,
// keeps the running checksum and the header spill position. Depends on eatfb_pkg.
module eatfb_back (
   input  logic               clock,
   input  logic               reset,
   input  eatfb_pkg::cfg_type cfg,
   input  logic               job_valid,
   output logic               job_ready,
   input  eatfb_pkg::job_type job,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output eatfb_pkg::rsp_type rsp
);

   logic                    job_valid_ff, job_valid_in;
   eatfb_pkg::job_kind_type job_kind_ff, job_kind_in;
   logic [7:0]              job_byte_ff, job_byte_in;
   logic                    esc_ff, esc_in;
   logic [63:0]             hdr_addr_ff, hdr_addr_in;
   logic [15:0]             hdr_len_ff, hdr_len_in;
   eatfb_pkg::cfg_type      hdr_cfg_ff, hdr_cfg_in;
   logic [4:0]              hdr_idx_ff, hdr_idx_in;
   logic                    hdr_pend_ff, hdr_pend_in;
   logic [4:0]              wire_cnt_ff, wire_cnt_in;
   logic [7:0]              sum_ff, sum_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   eatfb_pkg::rsp_type      rsp_ff, rsp_in;

   logic       emit_go;
   logic [7:0] hdr_raw;
   logic [7:0] raw;
   logic       needs;
   logic       raw_done;
   logic [7:0] wire_byte;
   logic       summed;
   logic       hdr_last;
   logic       start_cap;
   logic       job_done;

   assign emit_go   = job_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      case (hdr_idx_ff)
         5'd0:                     hdr_raw = eatfb_pkg::START_DELIM;
         eatfb_pkg::HDR_LEN_HI:    hdr_raw = hdr_len_ff[15:8];
         eatfb_pkg::HDR_LEN_LO:    hdr_raw = hdr_len_ff[7:0];
         eatfb_pkg::HDR_TYPE:      hdr_raw = eatfb_pkg::FRAME_TYPE_TX;
         eatfb_pkg::HDR_IDENT:     hdr_raw = hdr_cfg_ff.frame_ident;
         5'd5, 5'd6, 5'd7, 5'd8,
         5'd9, 5'd10, 5'd11, 5'd12: hdr_raw = hdr_addr_ff[63:56];
         eatfb_pkg::HDR_RSVD_HI:   hdr_raw = eatfb_pkg::RSVD_HI;
         eatfb_pkg::HDR_RSVD_LO:   hdr_raw = eatfb_pkg::RSVD_LO;
         eatfb_pkg::HDR_RADIUS:    hdr_raw = hdr_cfg_ff.broadcast_radius;
         eatfb_pkg::HDR_OPTIONS:   hdr_raw = hdr_cfg_ff.tx_options;
         default:                  hdr_raw = 8'h00;
      endcase
   end

   always_comb begin
      // pick the raw byte: pending header first, then the checksum for a finish job or the job's own byte
      if (hdr_pend_ff) begin
         raw = hdr_raw;
      end else if (job_kind_ff == eatfb_pkg::JOB_FINISH) begin
         raw = eatfb_pkg::CHECKSUM_BASE - sum_ff;
      end else begin
         raw = job_byte_ff;
      end
      needs     = (!hdr_pend_ff || (hdr_idx_ff != 5'd0)) && eatfb_pkg::needs_escape(raw);
      raw_done  = esc_ff || !needs;
      wire_byte = esc_ff ? (raw ^ eatfb_pkg::ESC_MASK) : (needs ? eatfb_pkg::ESC_BYTE : raw);
      summed    = hdr_pend_ff ? (hdr_idx_ff >= eatfb_pkg::HDR_TYPE)
                              : (job_kind_ff == eatfb_pkg::JOB_DATA);
      hdr_last  = hdr_pend_ff && raw_done && (hdr_idx_ff == eatfb_pkg::HDR_OPTIONS);
      start_cap = (job_kind_ff == eatfb_pkg::JOB_START) &&
                  (wire_cnt_ff == eatfb_pkg::START_WIRE_CAP - 5'd1);
      case (job_kind_ff)
         eatfb_pkg::JOB_START: job_done = hdr_last || start_cap;
         default:              job_done = !hdr_pend_ff && raw_done;
      endcase
   end

   assign job_ready = !job_valid_ff || (emit_go && job_done);

   always_comb begin
      job_valid_in = job_valid_ff;
      job_kind_in  = job_kind_ff;
      job_byte_in  = job_byte_ff;
      esc_in       = esc_ff;
      hdr_addr_in  = hdr_addr_ff;
      hdr_len_in   = hdr_len_ff;
      hdr_cfg_in   = hdr_cfg_ff;
      hdr_idx_in   = hdr_idx_ff;
      hdr_pend_in  = hdr_pend_ff;
      wire_cnt_in  = wire_cnt_ff;
      sum_in       = sum_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (emit_go) begin
         rsp_valid_in     = 1'b1;
         rsp_in.out_byte  = wire_byte;
         rsp_in.frame_end = (job_kind_ff == eatfb_pkg::JOB_FINISH) && job_done;
         rsp_in.run_last  = job_done;
         esc_in           = !raw_done;
         if (hdr_pend_ff && raw_done) begin
            hdr_idx_in = hdr_idx_ff + 5'd1;
            if ((hdr_idx_ff >= eatfb_pkg::HDR_ADDR_FIRST) &&
                (hdr_idx_ff <= eatfb_pkg::HDR_ADDR_LAST)) begin
               hdr_addr_in = {hdr_addr_ff[55:0], 8'h00};
            end
         end
         if (hdr_last) begin
            hdr_pend_in = 1'b0;
         end
         if (raw_done && summed) begin
            sum_in = sum_ff + raw;
         end
         if ((job_kind_ff == eatfb_pkg::JOB_FINISH) && job_done) begin
            sum_in = 8'h00;
         end
         if (job_kind_ff == eatfb_pkg::JOB_START) begin
            wire_cnt_in = wire_cnt_ff + 5'd1;
         end
      end

      if (job_ready) begin
         job_valid_in = job_valid;
         if (job_valid) begin
            job_kind_in = job.kind;
            job_byte_in = job.data_byte;
            if (job.kind == eatfb_pkg::JOB_START) begin
               // restart: drop any spill and clear the sum
               hdr_addr_in = job.dest_address;
               hdr_len_in  = job.frame_length;
               hdr_cfg_in  = cfg;
               hdr_idx_in  = 5'd0;
               hdr_pend_in = 1'b1;
               esc_in      = 1'b0;
               wire_cnt_in = 5'd0;
               sum_in      = 8'h00;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         esc_ff       <= 1'b0;
         hdr_idx_ff   <= 5'd0;
         hdr_pend_ff  <= 1'b0;
         wire_cnt_ff  <= 5'd0;
         sum_ff       <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         esc_ff       <= esc_in;
         hdr_idx_ff   <= hdr_idx_in;
         hdr_pend_ff  <= hdr_pend_in;
         wire_cnt_ff  <= wire_cnt_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_kind_ff <= job_kind_in;
      job_byte_ff <= job_byte_in;
      hdr_addr_ff <= hdr_addr_in;
      hdr_len_ff  <= hdr_len_in;
      hdr_cfg_ff  <= hdr_cfg_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// File: src/escaped_api_tx_frame_builder_unit.sv
// Top level of the escaped API transmit-request frame builder.
// Instantiates eatfb_front, eatfb_queue and eatfb_back; uses eatfb_pkg.
//
// Usage:
//   req_*  : command beats. Start carries dest_address and payload_length,
//            payload carries data_byte, finish closes the frame.
//   rsp_*  : one wire byte per beat, escaped; frame_end marks the checksum
//            byte, run_last the final beat caused by one request beat.
//   csr_*  : write frame_ident, broadcast_radius, tx_options while idle.
// Path: an accepted req beat reaches rsp through the queue register, the
//   sequencer job register, then the sequencer output register.
// Throughput: the sequencer emits one wire byte per cycle unless rsp stalls.
//   A payload beat yields one wire byte, or two if escaped, plus up to 3 header
//   bytes spilled from the start beat; a start beat yields 17 to 27 wire bytes;
//   the back end's byte rate sets the pace; the queue accepts until it is full.
// Reset: no frame open, queue empty, checksum zero, registers at defaults.
// Stall: when rsp_ready is low the output beat holds, the sequencer halts,
//   the queue fills and then req_ready drops.
module escaped_api_tx_frame_builder_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  eatfb_pkg::req_type req,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output eatfb_pkg::rsp_type rsp,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata
);

   eatfb_pkg::cfg_type cfg_ff, cfg_in;
   logic               push_valid;
   logic               push_ready;
   eatfb_pkg::job_type push_job;
   logic               pop_valid;
   logic               pop_ready;
   eatfb_pkg::job_type pop_job;

   // Register writes: indexes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            eatfb_pkg::CSR_FRAME_IDENT:      cfg_in.frame_ident      = csr_wdata;
            eatfb_pkg::CSR_BROADCAST_RADIUS: cfg_in.broadcast_radius = csr_wdata;
            eatfb_pkg::CSR_TX_OPTIONS:       cfg_in.tx_options       = csr_wdata;
            default:                         cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_ident      <= eatfb_pkg::FRAME_IDENT_RESET;
         cfg_ff.broadcast_radius <= 8'h00;
         cfg_ff.tx_options       <= 8'h00;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classify beats and drop those outside a frame.
   eatfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   // Decouple classification from byte sequencing.
   eatfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_job    (push_job),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_job   (pop_job)
   );

   // Expand jobs into escaped wire beats.
   eatfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job       (pop_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

endmodule

// File: src/eatfb_checker.sv
// Port-level checks for the escaped API transmit frame builder, bound to the
// top level. Depends on eatfb_pkg and the assertion macro header.
`include "escaped_api_tx_frame_builder_unit_macros.svh"

module eatfb_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input eatfb_pkg::rsp_type rsp
);

   // A stalled beat holds.
   `EATFB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

   // The checksum beat always ends its request's run.
   `EATFB_ASSERT_SAME(a_end_is_last, rsp_valid && rsp.frame_end, rsp.run_last)

   // Flow control bytes never reach the wire unescaped.
   `EATFB_ASSERT_SAME(a_no_flow_ctrl, rsp_valid, (rsp.out_byte != eatfb_pkg::XON_BYTE) && (rsp.out_byte != eatfb_pkg::XOFF_BYTE))

   // The final frame byte is never a bare escape prefix.
   `EATFB_ASSERT_SAME(a_end_not_esc, rsp_valid && rsp.frame_end, rsp.out_byte != eatfb_pkg::ESC_BYTE)

endmodule

bind escaped_api_tx_frame_builder_unit eatfb_checker u_checker (.*);
